/* rtl/bta_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the block table heap allocator.
package bta_pkg;

    localparam int ADDR_W   = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int TOTAL_W  = 11;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int RB_W     = 33;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMEM   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b1;

    // Bit positions of a table entry.
    localparam int F_TAKEN = 0;
    localparam int F_FIRST = 1;
    localparam int F_NEXT  = 2;

    typedef logic [2:0] entry_t;

    typedef struct packed {
        logic            load;
        logic            sweep;
        logic            scan;
        logic            mark;
        logic            walk_read;
        logic            walk;
        logic            finish;
        logic [ST_W-1:0] res_status;
    } bta_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            below_base;
        logic            sweep_last;
        logic            scan_found;
        logic            scan_fail;
        logic            mark_last;
        logic            idx_ok;
        logic            head_ok;
        logic            walk_last;
        logic            out_free;
    } bta_sts_t;

endpackage

/* rtl/bta_dp.sv */
`timescale 1ns / 1ps
// Datapath: block table memory, counters, index divider and result register.
module bta_dp
    import bta_pkg::*;
#(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic [63:0]          s_tdata,
    input  logic                 m_tready,
    input  bta_cmd_t             cmd,
    output bta_sts_t             sts,
    output logic                 m_tvalid,
    output logic [ADDR_W-1:0]    m_tdata,
    output logic [ST_W-1:0]      m_tuser
);

    localparam int IDX_W    = $clog2(NUM_BLOCKS);
    localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
    localparam int TW       = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
    localparam int BB_SHIFT = $clog2(BLOCK_BYTES);
    localparam logic [RB_W-1:0]   BB_RB  = RB_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] BB_A   = ADDR_W'(BLOCK_BYTES);

    entry_t table_mem [NUM_BLOCKS];

    logic [ADDR_W-1:0]  base_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [OP_W-1:0]    op_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ev_valid_reg, ev_valid_next;
    logic [CNT_W-1:0]   ev_idx_reg, ev_idx_next;
    logic [RB_W-1:0]    run_reg, run_next;
    logic [ADDR_W-1:0]  off_reg, off_next;
    logic [CNT_W-1:0]   start_idx_reg, start_idx_next;
    logic [ADDR_W-1:0]  start_off_reg, start_off_next;
    logic [RB_W-1:0]    left_reg, left_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [ADDR_W-1:0]  quo_reg, quo_next;
    logic               out_valid_reg, out_valid_next;
    logic [ST_W-1:0]    out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    entry_t             rd_data_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic [TW-1:0]      total_ext;
    logic [CNT_W-1:0]   eff_total;
    logic [RB_W-1:0]    run_plus;
    logic               scan_hit;
    logic [CNT_W-1:0]   found_start;
    logic [ADDR_W-1:0]  found_off;
    logic               mark_more;
    logic [CNT_W-1:0]   nxt_idx;
    logic               walk_more;
    logic               out_free;

    assign total_ext = TW'(total_reg);
    assign eff_total = (total_ext > TW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(total_reg);

    assign run_plus    = run_reg + BB_RB;
    assign scan_hit    = ev_valid_reg && !rd_data_reg[F_TAKEN]
                         && (run_plus >= {1'b0, size_reg});
    assign found_start = (run_reg == '0) ? ev_idx_reg : start_idx_reg;
    assign found_off   = (run_reg == '0) ? off_reg : start_off_reg;
    assign mark_more   = left_reg > BB_RB;
    assign nxt_idx     = ev_idx_reg + CNT_W'(1);
    assign walk_more   = rd_data_reg[F_NEXT] && (nxt_idx < eff_total);
    assign out_free    = !out_valid_reg || m_tready;

    always_comb
    begin
        sts.op         = op_reg;
        sts.size_zero  = size_reg == '0;
        sts.below_base = addr_reg < base_reg;
        sts.sweep_last = cnt_reg == CNT_W'(NUM_BLOCKS - 1);
        sts.scan_found = scan_hit;
        sts.scan_fail  = !ev_valid_reg && (cnt_reg >= eff_total);
        sts.mark_last  = !mark_more;
        sts.idx_ok     = quo_reg < ADDR_W'(eff_total);
        sts.head_ok    = rd_data_reg[F_TAKEN] && rd_data_reg[F_FIRST];
        sts.walk_last  = ev_valid_reg && !walk_more;
        sts.out_free   = out_free;
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        run_next        = run_reg;
        off_next        = off_reg;
        start_idx_next  = start_idx_reg;
        start_off_next  = start_off_reg;
        left_next       = left_reg;
        res_addr_next   = res_addr_reg;
        quo_next        = quo_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = cnt_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = cnt_reg[IDX_W-1:0];
        wr_data         = '0;

        if (cmd.load)
        begin
            cnt_next      = '0;
            ev_valid_next = 1'b0;
            run_next      = '0;
            off_next      = '0;
            // Block index of the address; the block size is a power of two.
            quo_next      = (s_tdata[63:32] - base_reg) >> BB_SHIFT;
        end

        if (cmd.sweep)
        begin
            wr_en    = 1'b1;
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.scan)
        begin
            // The read issued here is evaluated in the next cycle.
            if (cnt_reg < eff_total)
            begin
                rd_en         = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                ev_valid_next = 1'b1;
                ev_idx_next   = cnt_reg;
            end
            else
            begin
                ev_valid_next = 1'b0;
            end
            if (ev_valid_reg)
            begin
                off_next = off_reg + BB_A;
                if (rd_data_reg[F_TAKEN])
                begin
                    run_next = '0;
                end
                else
                begin
                    if (run_reg == '0)
                    begin
                        start_idx_next = ev_idx_reg;
                        start_off_next = off_reg;
                    end
                    run_next = run_plus;
                end
            end
            if (scan_hit)
            begin
                cnt_next      = found_start;
                left_next     = {1'b0, size_reg};
                res_addr_next = base_reg + found_off;
            end
        end

        if (cmd.mark)
        begin
            wr_en            = 1'b1;
            wr_data[F_TAKEN] = 1'b1;
            wr_data[F_FIRST] = cnt_reg == start_idx_reg;
            wr_data[F_NEXT]  = mark_more;
            left_next        = left_reg - BB_RB;
            cnt_next         = cnt_reg + CNT_W'(1);
        end

        if (cmd.walk_read)
        begin
            rd_en         = 1'b1;
            rd_addr       = quo_reg[IDX_W-1:0];
            ev_valid_next = 1'b1;
            ev_idx_next   = quo_reg[CNT_W-1:0];
        end

        if (cmd.walk)
        begin
            if (ev_valid_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = ev_idx_reg[IDX_W-1:0];
            end
            if (ev_valid_reg && walk_more)
            begin
                rd_en         = 1'b1;
                rd_addr       = nxt_idx[IDX_W-1:0];
                ev_valid_next = 1'b1;
                ev_idx_next   = nxt_idx;
            end
            else
            begin
                ev_valid_next = 1'b0;
            end
        end

        if (cmd.finish && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.res_status;
            out_addr_next   = (cmd.res_status == ST_OK && op_reg == OP_ALLOC)
                              ? res_addr_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            total_reg     <= TOTAL_RESET;
            cnt_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_HEAP_BASE)
            begin
                base_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_TOTAL_BLOCKS)
            begin
                total_reg <= cfg_wdata[TOTAL_W-1:0];
            end
            cnt_reg       <= cnt_next;
            ev_valid_reg  <= ev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_tuser;
            size_reg <= s_tdata[31:0];
            addr_reg <= s_tdata[63:32];
        end
        ev_idx_reg     <= ev_idx_next;
        run_reg        <= run_next;
        off_reg        <= off_next;
        start_idx_reg  <= start_idx_next;
        start_off_reg  <= start_off_next;
        left_reg       <= left_next;
        res_addr_reg   <= res_addr_next;
        quo_reg        <= quo_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

endmodule

/* rtl/bta_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences the allocator datapath.
module bta_ctrl
    import bta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  bta_sts_t sts,
    output bta_cmd_t cmd
);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_MARK = 4'd5;
    localparam logic [3:0] S_HEAD = 4'd6;
    localparam logic [3:0] S_WALK = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [ST_W-1:0] status_reg, status_next;

    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.res_status = status_reg;

        case (state_reg)
            S_INIT:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.size_zero)
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.below_base)
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                        else if (sts.idx_ok)
                        begin
                            cmd.walk_read = 1'b1;
                            state_next    = S_HEAD;
                        end
                        else
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        state_next = S_CLR;
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_CLR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_MARK;
                end
                else if (sts.scan_fail)
                begin
                    status_next = ST_NOMEM;
                    state_next  = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (sts.mark_last)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_HEAD:
            begin
                // Only the start of an allocation may be freed.
                if (sts.head_ok)
                begin
                    cmd.walk = 1'b1;
                    if (sts.walk_last)
                    begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_last)
                begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

/* rtl/block_table_heap_allocator.sv */
`timescale 1ns / 1ps
// Top level of the block table first-fit heap allocator.
//
// One request is worked at a time, and its result is held in an output register so the
// next request is taken while the result waits. After reset the table is swept to free
// with s_tready low. BLOCK_BYTES must be a power of two, so a free turns its address into
// a block index with a shift. The table memory has one read and one write port, and every
// walk is bound by it at one entry a cycle: an allocate scans entries and then marks the
// blocks of the run; a free reads the head entry and walks the chain of the allocation;
// a clear sweeps the whole table. A free that names a block that is not the start of an
// allocation is rejected.
module block_table_heap_allocator
    import bta_pkg::*;
#(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // size_bytes[31:0], address[63:32]
    input  logic [OP_W-1:0]      s_tuser,   // operation[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ADDR_W-1:0]    m_tdata,   // block_address[31:0]
    output logic [ST_W-1:0]      m_tuser    // status[1:0]
);

    bta_cmd_t cmd;
    bta_sts_t sts;

    bta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bta_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/bta_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the allocator and its bind to the top level.
module bta_checker
    import bta_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [ADDR_W-1:0] m_tdata,
    input logic [ST_W-1:0]   m_tuser
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_INVALID || m_tuser == ST_NOMEM))
        else $error("unknown status code");

    // Only a successful request carries an address.
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
        else $error("failed request returned a nonzero address");

    // One request is worked at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while a request is in progress");

endmodule

bind block_table_heap_allocator bta_checker u_bta_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/block_table_heap_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the block table first-fit heap allocator.
module block_table_heap_allocator_tb;
    import bta_pkg::*;

    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_BYTES = 4096;
    localparam int IDLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES = 2 * NUM_BLOCKS + 64;
    localparam logic [31:0] ALIGN_MASK = ~(BLOCK_BYTES - 1);
    // Operation code 3 is not defined by the block and must be rejected.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] block_address;
    } alloc_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;   // size_bytes[31:0], address[63:32]
    logic [OP_W-1:0]      s_tuser;   // operation[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ADDR_W-1:0]    m_tdata;   // block_address[31:0]
    logic [ST_W-1:0]      m_tuser;   // status[1:0]

    // Shadow copy of the allocation table and the registers.
    entry_t        block_flags [NUM_BLOCKS];
    logic [31:0]   heap_base;
    logic [10:0]   heap_total;

    alloc_result_t expected_results [$];
    alloc_result_t oldest_result;

    bit tx_idle_on;
    bit rx_idle_on;
    int fail_count;
    int requests_sent;
    int results_checked;
    int settings_used;
    int ok_count;
    int invalid_count;
    int nomem_count;
    int idle_cycles;

    block_table_heap_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int effective_blocks();
        return (heap_total > NUM_BLOCKS) ? NUM_BLOCKS : int'(heap_total);
    endfunction

    // Applies one request to the shadow table and returns the result it must produce.
    function automatic alloc_result_t predict_result(input logic [OP_W-1:0] op,
                                                     input logic [31:0] size,
                                                     input logic [31:0] addr);
        alloc_result_t res;
        int            eff;
        logic [63:0]   need;
        int unsigned   idx;
        int            start;
        int            run;
        int            i;
        bit            found;
        bit            more;
        entry_t        entry;
        res.status        = ST_INVALID;
        res.block_address = '0;
        eff = effective_blocks();
        case (op)
            OP_ALLOC:
            begin
                need = ({32'b0, size} + 64'(BLOCK_BYTES - 1)) / BLOCK_BYTES;
                if (size == 0)
                    res.status = ST_INVALID;
                else if (need > eff)
                    res.status = ST_NOMEM;
                else
                begin
                    found = 1'b0;
                    run   = 0;
                    start = 0;
                    for (i = 0; i < eff && !found; i++)
                    begin
                        if (block_flags[i][F_TAKEN])
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                start = i;
                            run++;
                            if (run == need)
                                found = 1'b1;
                        end
                    end
                    if (!found)
                        res.status = ST_NOMEM;
                    else
                    begin
                        for (i = start; i < start + need; i++)
                        begin
                            entry          = '0;
                            entry[F_TAKEN] = 1'b1;
                            entry[F_FIRST] = (i == start);
                            entry[F_NEXT]  = (i + 1 < start + need);
                            block_flags[i] = entry;
                        end
                        res.status        = ST_OK;
                        res.block_address = heap_base + 32'(start) * BLOCK_BYTES;
                    end
                end
            end
            OP_FREE:
            begin
                if (addr >= heap_base)
                begin
                    idx = (addr - heap_base) / BLOCK_BYTES;
                    if (idx < eff && block_flags[idx][F_TAKEN] && block_flags[idx][F_FIRST])
                    begin
                        // The chain ends at the first entry without has-next or at the
                        // effective block count, whichever comes first.
                        more = 1'b1;
                        for (i = idx; i < eff && more; i++)
                        begin
                            more           = block_flags[i][F_NEXT];
                            block_flags[i] = '0;
                        end
                        res.status = ST_OK;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < NUM_BLOCKS; i++)
                    block_flags[i] = '0;
                res.status = ST_OK;
            end
            default:
                res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [31:0] size,
                                input logic [31:0] addr);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 45)
            gap = idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {addr, size};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(predict_result(op, size, addr));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Both registers are written back to back; the block must be idle when this is called.
    task automatic write_registers(input logic [31:0] base, input logic [10:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEAP_BASE;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_index <= CFG_TOTAL_BLOCKS;
        cfg_wdata <= {21'b0, total};
        @(posedge clk);
        cfg_we     <= 1'b0;
        heap_base  = base;
        heap_total = total;
        settings_used++;
    endtask

    task automatic send_random_request();
        int              eff;
        int              pick;
        int              blocks;
        int              r;
        int              i;
        int              starts [$];
        logic [OP_W-1:0] op;
        logic [31:0]     size;
        logic [31:0]     addr;
        eff  = effective_blocks();
        pick = $urandom_range(0, 99);
        op   = OP_ALLOC;
        size = $urandom;
        addr = $urandom;
        if (pick < 45)
        begin
            blocks = 1;
            if (eff > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    blocks = $urandom_range(1, (eff < 8) ? eff : 8);
                else if (r < 95)
                    blocks = $urandom_range(1, (eff / 2 > 1) ? eff / 2 : 1);
                else
                    blocks = $urandom_range(1, eff);
            end
            size = (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
        end
        else if (pick < 80)
        begin
            // Release a live allocation, pointing anywhere inside its first block.
            op = OP_FREE;
            for (i = 0; i < eff; i++)
                if (block_flags[i][F_TAKEN] && block_flags[i][F_FIRST])
                    starts.push_back(i);
            if (starts.size() > 0)
                addr = heap_base + starts[$urandom_range(0, starts.size() - 1)] * BLOCK_BYTES
                       + $urandom_range(0, BLOCK_BYTES - 1);
        end
        else if (pick < 86)
        begin
            op   = OP_FREE;
            addr = heap_base + $urandom_range(0, eff + 2) * BLOCK_BYTES
                   + $urandom_range(0, BLOCK_BYTES - 1);
        end
        else if (pick < 93)
            op = OP_W'($urandom_range(0, 3));
        else if (pick < 97)
            op = OP_UNUSED;
        else
            op = OP_CLEAR;
        send_request(op, size, addr);
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [10:0] total, input int count,
                             input bit tx_idle, input bit rx_idle);
        int n;
        wait_for_results();
        write_registers(base, total);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        for (n = 0; n < count; n++)
            send_random_request();
    endtask

    task automatic test_request_corners();
        send_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        send_request(OP_ALLOC, BLOCK_BYTES, 32'd0);
        send_request(OP_ALLOC, BLOCK_BYTES + 1, 32'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Second block of a two-block run is not an allocation start.
        send_request(OP_FREE, 32'd0, 3 * BLOCK_BYTES);
        send_request(OP_FREE, 32'd0, 2 * BLOCK_BYTES + 12'hABC);
        send_request(OP_FREE, 32'd0, NUM_BLOCKS * BLOCK_BYTES);
        send_request(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        send_request(OP_CLEAR, 32'd0, 32'd0);
        send_request(OP_ALLOC, NUM_BLOCKS * BLOCK_BYTES, 32'd0);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        send_request(OP_FREE, 32'd0, 32'd0);
    endtask

    task automatic test_register_effects();
        wait_for_results();
        write_registers(32'hFFFF_F000, 11'h7FF);
        send_request(OP_FREE, 32'd0, 32'd0);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        // The second run lies past the top of the address space and wraps to zero.
        send_request(OP_ALLOC, 2 * BLOCK_BYTES, 32'd0);
        send_request(OP_FREE, 32'd0, 32'hFFFF_F000);
        send_request(OP_CLEAR, 32'd0, 32'd0);
        wait_for_results();
        write_registers(32'h0001_0000, 11'd16);
        send_request(OP_ALLOC, 8 * BLOCK_BYTES, 32'd0);
        // With fewer blocks in use the chain walk must stop at the new count.
        wait_for_results();
        write_registers(32'h0001_0000, 11'd4);
        send_request(OP_FREE, 32'd0, 32'h0001_0000);
        wait_for_results();
        write_registers(32'h0001_0000, 11'd16);
        send_request(OP_ALLOC, BLOCK_BYTES, 32'd0);
        send_request(OP_ALLOC, 5 * BLOCK_BYTES, 32'd0);
        wait_for_results();
        write_registers(32'h0001_0000, 11'd0);
        send_request(OP_ALLOC, 32'd1, 32'd0);
        send_request(OP_FREE, 32'd0, 32'h0001_0000);
        send_request(OP_CLEAR, 32'd0, 32'd0);
    endtask

    task automatic test_random_traffic();
        run_phase($urandom & ALIGN_MASK, 11'd16, 60, 1'b1, 1'b1);
        run_phase(32'd0, 11'd1, 40, 1'b0, 1'b0);
        run_phase($urandom & ALIGN_MASK, 11'd2, 40, 1'b1, 1'b1);
        run_phase(32'hFFFC_0000, 11'd128, 70, 1'b1, 1'b1);
        run_phase($urandom, 11'd40, 60, 1'b1, 1'b0);
        run_phase($urandom & ALIGN_MASK, 11'd1024, 60, 1'b0, 1'b1);
        run_phase(32'h7FFF_F000, 11'h7FF, 60, 1'b1, 1'b1);
        run_phase($urandom & ALIGN_MASK, 11'($urandom_range(3, 100)), 60, 1'b1, 1'b1);
        run_phase($urandom & ALIGN_MASK, 11'd0, 20, 1'b1, 1'b1);
        run_phase($urandom & ALIGN_MASK, 11'd32, 85, 1'b0, 1'b0);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 25)
                stall_left = idle_length();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d, block_address %h",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                results_checked++;
                case (oldest_result.status)
                    ST_OK:      ok_count++;
                    ST_NOMEM:   nomem_count++;
                    default:    invalid_count++;
                endcase
                if (m_tuser !== oldest_result.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_result.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== oldest_result.block_address)
                begin
                    $error("block_address: expected %h, got %h",
                           oldest_result.block_address, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run when neither side has moved a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("block_table_heap_allocator verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        for (i = 0; i < NUM_BLOCKS; i++)
            block_flags[i] = '0;
        heap_base       = '0;
        heap_total      = TOTAL_RESET;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        settings_used   = 1;
        ok_count        = 0;
        invalid_count   = 0;
        nomem_count     = 0;
        idle_cycles     = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HEAP_BASE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ALLOC;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_request_corners();
        test_register_effects();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests under %0d register settings, checked %0d results.",
                 requests_sent, settings_used, results_checked);
        $display("Results seen: %0d ok, %0d invalid argument, %0d out of memory.",
                 ok_count, invalid_count, nomem_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("block_table_heap_allocator verification clean");
        else
            $display("block_table_heap_allocator verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/bta_pkg.sv
rtl/bta_dp.sv
rtl/bta_ctrl.sv
rtl/block_table_heap_allocator.sv
rtl/bta_checker.sv
sim/block_table_heap_allocator_tb.sv
